// File: sv/shm_pkg.sv
`default_nettype none

package shm_pkg;

    // Field widths
    localparam int ENERGY_WIDTH = 16;
    localparam int COS_WIDTH    = 16;
    localparam int SUM_WIDTH    = 18;
    localparam int COUNT_WIDTH  = 2;
    localparam int PROD_WIDTH   = SUM_WIDTH + COS_WIDTH;
    localparam int COS_FRAC     = 15;

    // Largest cluster size before a forced emit
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 2'd3;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_CLUSTER_MODE   = 2'd0,
        REG_LOW_CUT        = 2'd1,
        REG_QUIET_NEXT_CUT = 2'd2
    } cfg_index_t;

    localparam logic [ENERGY_WIDTH-1:0] LOW_CUT_RESET        = ENERGY_WIDTH'(205);
    localparam logic [ENERGY_WIDTH-1:0] QUIET_NEXT_CUT_RESET = ENERGY_WIDTH'(10);

    // Configuration registers
    typedef struct packed {
        logic                    cluster_mode;
        logic [ENERGY_WIDTH-1:0] low_cut;
        logic [ENERGY_WIDTH-1:0] quiet_next_cut;
    } cfg_t;

    // One strip
    typedef struct packed {
        logic                    sector_start;
        logic                    strip_valid;
        logic [ENERGY_WIDTH-1:0] energy;
        logic [ENERGY_WIDTH-1:0] prev_energy;
        logic [ENERGY_WIDTH-1:0] next_energy;
        logic [ENERGY_WIDTH-1:0] upper_cut;
        logic [COS_WIDTH-1:0]    cos_theta;
    } strip_t;

    // Merging state carried from strip to strip
    typedef struct packed {
        logic [SUM_WIDTH-1:0]   cluster_sum;
        logic [COUNT_WIDTH-1:0] cluster_count;
        logic                   shared_with_next;
        logic                   shared_with_prev;
    } merge_state_t;

    // Result of one strip
    typedef struct packed {
        logic [SUM_WIDTH-1:0] hit_energy;
        logic                 hit;
    } result_t;

    // Saturating add of a sum and an energy
    function automatic logic [SUM_WIDTH-1:0] sat_add(input logic [SUM_WIDTH-1:0] a,
                                                     input logic [ENERGY_WIDTH-1:0] b);
        logic [SUM_WIDTH:0] s;
        s = {1'b0, a} + (SUM_WIDTH+1)'(b);
        return s[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : s[SUM_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/shm_step.sv
`default_nettype none

// Next-state and result logic for one strip: compares, one add chain, one multiply
module shm_step (
    input  wire  shm_pkg::cfg_t         cfg,
    input  wire  shm_pkg::strip_t       strip,
    input  wire  shm_pkg::merge_state_t state,
    output shm_pkg::merge_state_t       state_next,
    output shm_pkg::result_t            result
);
    import shm_pkg::*;

    merge_state_t           st;
    logic                   active;
    logic                   e_above;
    logic [SUM_WIDTH-1:0]   sum_acc;
    logic [COUNT_WIDTH-1:0] cnt_acc;
    logic                   emit;
    logic [SUM_WIDTH-1:0]   total;
    logic                   take_prev;
    logic                   take_next;
    logic [SUM_WIDTH-1:0]   scale_op;
    logic [PROD_WIDTH-1:0]  prod;
    logic [PROD_WIDTH:0]    rounded;
    logic [SUM_WIDTH-1:0]   scaled;
    logic                   nonzero;

    // Sector start clears state before the strip is used
    assign st     = strip.sector_start ? '0 : state;
    assign active = strip.strip_valid && (strip.energy != '0);

    // Cluster accumulation
    assign e_above = strip.energy > cfg.low_cut;
    assign sum_acc = e_above ? sat_add(st.cluster_sum, strip.energy) : st.cluster_sum;
    assign cnt_acc = (e_above && st.cluster_count < COUNT_MAX)
                   ? st.cluster_count + COUNT_WIDTH'(1) : st.cluster_count;
    assign emit    = ((strip.next_energy < cfg.quiet_next_cut) && (sum_acc != '0))
                   || (cnt_acc == COUNT_MAX);

    // Neighbor sharing sum
    assign take_prev = (strip.prev_energy > cfg.low_cut) && (strip.prev_energy < strip.upper_cut)
                     && !st.shared_with_prev;
    assign take_next = (strip.next_energy > cfg.low_cut) && (strip.next_energy < strip.upper_cut);

    always_comb
    begin
        total = SUM_WIDTH'(strip.energy);
        if (take_prev)
            total = sat_add(total, strip.prev_energy);
        if (take_next)
            total = sat_add(total, strip.next_energy);
    end

    // Cosine scaling, round half up, saturate
    assign scale_op = cfg.cluster_mode ? sum_acc : total;
    assign prod     = scale_op * strip.cos_theta;
    assign rounded  = {1'b0, prod} + (PROD_WIDTH+1)'(1 << (COS_FRAC - 1));
    assign scaled   = (|rounded[PROD_WIDTH:SUM_WIDTH+COS_FRAC])
                    ? {SUM_WIDTH{1'b1}} : rounded[SUM_WIDTH+COS_FRAC-1:COS_FRAC];
    assign nonzero  = scaled != '0;

    // State update and result selection
    always_comb
    begin
        state_next = st;
        result     = '0;
        if (active)
        begin
            if (cfg.cluster_mode)
            begin
                state_next.cluster_sum   = sum_acc;
                state_next.cluster_count = cnt_acc;
                if (emit)
                begin
                    state_next.cluster_sum   = '0;
                    state_next.cluster_count = '0;
                    result.hit_energy        = scaled;
                    result.hit               = nonzero;
                end
            end
            else if (st.shared_with_next)
            begin
                state_next.shared_with_next = 1'b0;
                state_next.shared_with_prev = 1'b1;
            end
            else if (strip.energy < cfg.low_cut)
            begin
                state_next.shared_with_next = 1'b0;
                state_next.shared_with_prev = 1'b0;
            end
            else
            begin
                result.hit_energy = scaled;
                result.hit        = nonzero;
                if (nonzero)
                begin
                    state_next.shared_with_next = take_next;
                    state_next.shared_with_prev = 1'b1;
                end
                else
                begin
                    state_next.shared_with_next = 1'b0;
                    state_next.shared_with_prev = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/strip_hit_sharing_merger.sv
`default_nettype none

// Strip hit-sharing merger. One strip request per cycle enters on the s_axis side, unless
// m_axis_tready stalls the output, and gives exactly one result on the m_axis side, in order.
// Each strip passes an input register, then a result register, with the combinational
// step logic (one 18x16 multiply) between them. The merge state (cluster sum, count,
// sharing flags) is updated as each strip moves into the result register, so consecutive
// strips chain without bubbles. Configuration registers are written over the cfg channel,
// which is always ready; write them only while idle.
module strip_hit_sharing_merger (
    input  wire         clk,
    input  wire         rst_n,
    // Strip requests
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [79:0] s_axis_tdata,  // energy, prev_energy, next_energy, upper_cut, cos_theta
    input  wire  [1:0]  s_axis_tuser,  // sector_start, strip_valid
    // Results
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,  // hit_energy, zero fill
    output logic        m_axis_tuser,  // hit
    // Configuration writes
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);
    import shm_pkg::*;

    cfg_t         cfg_reg;
    strip_t       strip_reg;
    logic         in_valid_reg;
    merge_state_t state_reg;
    merge_state_t state_next;
    result_t      result_next;
    result_t      result_reg;
    logic         out_valid_reg;
    logic         out_free;
    logic         advance;
    strip_t       strip_in;

    // Configuration port
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cluster_mode   <= 1'b0;
            cfg_reg.low_cut        <= LOW_CUT_RESET;
            cfg_reg.quiet_next_cut <= QUIET_NEXT_CUT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CLUSTER_MODE:   cfg_reg.cluster_mode   <= cfg_data[0];
                REG_LOW_CUT:        cfg_reg.low_cut        <= cfg_data[ENERGY_WIDTH-1:0];
                REG_QUIET_NEXT_CUT: cfg_reg.quiet_next_cut <= cfg_data[ENERGY_WIDTH-1:0];
                default:            ;
            endcase
        end
    end

    // Unpack the strip request
    assign strip_in.sector_start = s_axis_tuser[0];
    assign strip_in.strip_valid  = s_axis_tuser[1];
    assign strip_in.energy       = s_axis_tdata[15:0];
    assign strip_in.prev_energy  = s_axis_tdata[31:16];
    assign strip_in.next_energy  = s_axis_tdata[47:32];
    assign strip_in.upper_cut    = s_axis_tdata[63:48];
    assign strip_in.cos_theta    = s_axis_tdata[79:64];

    // Pipeline flow control
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            strip_reg <= strip_in;
    end

    // Step logic
    shm_step u_step (
        .cfg        (cfg_reg),
        .strip      (strip_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Merge state, updated as each strip completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(24-SUM_WIDTH){1'b0}}, result_reg.hit_energy};
    assign m_axis_tuser  = result_reg.hit;

endmodule

`default_nettype wire
